// ----- src/ippm_pkg.sv -----
// ----------------------------------------------------------------------------
// ippm_pkg
// Shared types and constants for the inverse perspective pixel map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ippm_pkg;

    localparam int COORD_BITS = 16;
    localparam int SHIFT_W    = $clog2(COORD_BITS);
    localparam int PROD_W     = 49;   // 32-bit signed times 17-bit signed
    localparam int SUM_W      = 51;   // three-term row sum
    localparam int NUM_W      = 60;   // 2*64*X + W
    localparam int DEN_W      = 52;   // 2*|W|
    localparam int REM_W      = DEN_W + COORD_BITS;

    // Register indexes of the configuration port
    localparam logic [3:0] CFG_ROW0_LIN = 4'd0;
    localparam logic [3:0] CFG_ROW0_OFF = 4'd1;
    localparam logic [3:0] CFG_ROW1_LIN = 4'd2;
    localparam logic [3:0] CFG_ROW1_OFF = 4'd3;
    localparam logic [3:0] CFG_ROW2_LIN = 4'd4;
    localparam logic [3:0] CFG_ROW2_OFF = 4'd5;
    localparam logic [3:0] CFG_SRC_W    = 4'd6;
    localparam logic [3:0] CFG_SRC_H    = 4'd7;

    typedef struct packed {
        logic [63:0] row0_lin;
        logic [47:0] row0_off;
        logic [63:0] row1_lin;
        logic [47:0] row1_off;
        logic [63:0] row2_lin;
        logic [31:0] row2_off;
        logic [15:0] src_w;
        logic [15:0] src_h;
    } t_cfg;

    // Payload handed from cell to cell of the divider row
    typedef struct packed {
        logic                  ok;
        logic [REM_W-1:0]      rem_x;
        logic [REM_W-1:0]      rem_y;
        logic [DEN_W-1:0]      den;
        logic [COORD_BITS-1:0] q_x;
        logic [COORD_BITS-1:0] q_y;
    } t_cell;

endpackage

`default_nettype wire

// ----- src/ippm_front.sv -----
// ----------------------------------------------------------------------------
// ippm_front
// Matrix rows, sign fix, rounding offset and range check before the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ippm_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_vld,
    input  wire logic [ippm_pkg::COORD_BITS-1:0] i_cx,
    input  wire logic [ippm_pkg::COORD_BITS-1:0] i_cy,
    input  wire ippm_pkg::t_cfg                  i_cfg,
    output logic                                 o_vld,
    output ippm_pkg::t_cell                      o_d
);
    import ippm_pkg::*;

    logic [4:0] r_vld;

    logic signed [PROD_W-1:0] r_pax, r_pbx, r_pay, r_pby, r_pg, r_ph;
    logic signed [SUM_W-1:0]  r_nx, r_ny, r_w;
    logic signed [SUM_W-1:0]  r_fx, r_fy;
    logic [SUM_W-1:0]         r_wa;
    logic                     r_wnz;
    logic signed [NUM_W-1:0]  r_n_x, r_n_y;
    logic [DEN_W-1:0]         r_den;
    logic                     r_ok4;
    t_cell                    r_out;

    logic signed [16:0] s_cx, s_cy;
    logic signed [NUM_W-1:0] n_n_x, n_n_y;
    logic [REM_W-1:0] s_lim;
    t_cell n_out;

    assign s_cx = $signed({1'b0, i_cx});
    assign s_cy = $signed({1'b0, i_cy});

    always_comb begin
        n_n_x = (NUM_W'(r_fx) <<< 7) + NUM_W'(signed'({1'b0, r_wa}));
        n_n_y = (NUM_W'(r_fy) <<< 7) + NUM_W'(signed'({1'b0, r_wa}));
        s_lim = REM_W'(r_den) << COORD_BITS;
        n_out.ok    = r_ok4 && (REM_W'(unsigned'(r_n_x)) < s_lim)
                            && (REM_W'(unsigned'(r_n_y)) < s_lim);
        n_out.rem_x = REM_W'(unsigned'(r_n_x));
        n_out.rem_y = REM_W'(unsigned'(r_n_y));
        n_out.den   = r_den;
        n_out.q_x   = '0;
        n_out.q_y   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products
            r_pax <= PROD_W'($signed(i_cfg.row0_lin[63:32]) * s_cx);
            r_pbx <= PROD_W'($signed(i_cfg.row0_lin[31:0]) * s_cy);
            r_pay <= PROD_W'($signed(i_cfg.row1_lin[63:32]) * s_cx);
            r_pby <= PROD_W'($signed(i_cfg.row1_lin[31:0]) * s_cy);
            r_pg  <= PROD_W'($signed(i_cfg.row2_lin[63:32]) * s_cx);
            r_ph  <= PROD_W'($signed(i_cfg.row2_lin[31:0]) * s_cy);
            // row sums
            r_nx <= SUM_W'(r_pax) + SUM_W'(r_pbx) + SUM_W'($signed(i_cfg.row0_off));
            r_ny <= SUM_W'(r_pay) + SUM_W'(r_pby) + SUM_W'($signed(i_cfg.row1_off));
            r_w  <= SUM_W'(r_pg) + SUM_W'(r_ph) + SUM_W'($signed(i_cfg.row2_off));
            // make the denominator positive
            r_fx  <= r_w[SUM_W-1] ? -r_nx : r_nx;
            r_fy  <= r_w[SUM_W-1] ? -r_ny : r_ny;
            r_wa  <= r_w[SUM_W-1] ? unsigned'(-r_w) : unsigned'(r_w);
            r_wnz <= (r_w != '0);
            // add half a pixel, double the denominator
            r_n_x <= n_n_x;
            r_n_y <= n_n_y;
            r_den <= {r_wa, 1'b0};
            r_ok4 <= r_wnz && (n_n_x > 0) && (n_n_y > 0);
            // drop quotients that need more than COORD_BITS bits
            r_out <= n_out;
        end
    end

    assign o_vld = r_vld[4];
    assign o_d   = r_out;

endmodule

`default_nettype wire

// ----- src/ippm_div_cell.sv -----
// ----------------------------------------------------------------------------
// ippm_div_cell
// One restoring division step for both axes: one quotient bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ippm_div_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [ippm_pkg::SHIFT_W-1:0] i_shift,
    input  wire logic                         i_vld,
    input  wire ippm_pkg::t_cell              i_d,
    output logic                              o_vld,
    output ippm_pkg::t_cell                   o_d
);
    import ippm_pkg::*;

    logic       r_vld;
    t_cell      r_d;
    t_cell      n_d;
    logic [REM_W-1:0] s_dsh;
    logic       s_gx, s_gy;

    always_comb begin
        s_dsh = REM_W'(i_d.den) << i_shift;
        s_gx  = i_d.rem_x >= s_dsh;
        s_gy  = i_d.rem_y >= s_dsh;
        n_d       = i_d;
        n_d.rem_x = s_gx ? i_d.rem_x - s_dsh : i_d.rem_x;
        n_d.rem_y = s_gy ? i_d.rem_y - s_dsh : i_d.rem_y;
        n_d.q_x   = {i_d.q_x[COORD_BITS-2:0], s_gx};
        n_d.q_y   = {i_d.q_y[COORD_BITS-2:0], s_gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

// ----- src/inverse_perspective_pixel_map.sv -----
// ----------------------------------------------------------------------------
// inverse_perspective_pixel_map
// Canvas pixel to source pixel through a projective matrix, nearest neighbor.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: canvas column, canvas row
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: source_col, source_row;
//                                              tuser: map_valid
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One transfer per clock in and out while m_axis_tready is high. Stages: five
// front stages (multiply, row sum, sign fix, half-pixel offset, range check),
// one cell of the divider row per quotient bit (16) and the output register.
// Reset is synchronous, active low; it clears valid bits and loads the
// identity matrix and a 1920x1080 source.
// A stalled output parks one result in a skid register; the pipeline stops
// only once that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module inverse_perspective_pixel_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] canvas column, [31:16] canvas row
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] source_col, [31:16] source_row
    output logic             m_axis_tuser,   // [0] map_valid
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import ippm_pkg::*;

    t_cfg r_cfg;

    // Configuration registers: always ready, unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row0_lin <= 64'h0100_0000_0000_0000;
            r_cfg.row0_off <= '0;
            r_cfg.row1_lin <= 64'h0000_0000_0100_0000;
            r_cfg.row1_off <= '0;
            r_cfg.row2_lin <= '0;
            r_cfg.row2_off <= 32'h4000_0000;
            r_cfg.src_w    <= 16'd1920;
            r_cfg.src_h    <= 16'd1080;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW0_LIN: r_cfg.row0_lin <= i_cfg_data;
                CFG_ROW0_OFF: r_cfg.row0_off <= i_cfg_data[47:0];
                CFG_ROW1_LIN: r_cfg.row1_lin <= i_cfg_data;
                CFG_ROW1_OFF: r_cfg.row1_off <= i_cfg_data[47:0];
                CFG_ROW2_LIN: r_cfg.row2_lin <= i_cfg_data;
                CFG_ROW2_OFF: r_cfg.row2_off <= i_cfg_data[31:0];
                CFG_SRC_W:    r_cfg.src_w    <= i_cfg_data[15:0];
                CFG_SRC_H:    r_cfg.src_h    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: hold everything only while the skid register is full
    logic r_skid_vld;
    logic s_en;
    assign s_en          = !r_skid_vld;
    assign s_axis_tready = s_en;

    logic  w_vld [COORD_BITS+1];
    t_cell w_d   [COORD_BITS+1];

    ippm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_vld   (s_axis_tvalid),
        .i_cx    (s_axis_tdata[COORD_BITS-1:0]),
        .i_cy    (s_axis_tdata[16+COORD_BITS-1:16]),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld[0]),
        .o_d     (w_d[0])
    );

    // Divider row: cell i settles quotient bit COORD_BITS-1-i
    for (genvar gi = 0; gi < COORD_BITS; gi++) begin : g_cell
        ippm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_shift (SHIFT_W'(COORD_BITS - 1 - gi)),
            .i_vld   (w_vld[gi]),
            .i_d     (w_d[gi]),
            .o_vld   (w_vld[gi+1]),
            .o_d     (w_d[gi+1])
        );
    end

    // Final bounds test and invalid marking
    t_cell s_last;
    logic  s_ok;
    logic [32:0] s_res;
    assign s_last = w_d[COORD_BITS];
    assign s_ok   = s_last.ok && (s_last.q_x < r_cfg.src_w[COORD_BITS-1:0])
                              && (s_last.q_y < r_cfg.src_h[COORD_BITS-1:0]);
    assign s_res  = s_ok ? {1'b1, 16'(s_last.q_y), 16'(s_last.q_x)}
                         : {1'b0, 16'({COORD_BITS{1'b1}}), 16'({COORD_BITS{1'b1}})};

    logic        r_o_vld;
    logic [32:0] r_o_res, r_skid_res;
    logic        s_out_free, s_push;
    assign s_out_free = !r_o_vld || m_axis_tready;
    assign s_push     = s_en && w_vld[COORD_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (s_out_free) begin
                r_o_vld <= r_skid_vld || s_push;
                r_skid_vld <= 1'b0;
            end else if (s_push) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free) begin
            r_o_res <= r_skid_vld ? r_skid_res : s_res;
        end else if (s_push) begin
            r_skid_res <= s_res;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_res[31:0];
    assign m_axis_tuser  = r_o_res[32];

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_o_vld)
        else $error("skid register full with empty output");
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_o_vld && !m_axis_tready))
        else $error("skid register loaded without a stall");
    a_invalid_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser)
            |-> (m_axis_tdata == {2{16'({COORD_BITS{1'b1}})}}))
        else $error("invalid result without all-ones coordinates");
`endif

endmodule

`default_nettype wire

// ----- verif/inverse_perspective_pixel_map_tb.sv -----
// ----------------------------------------------------------------------------
// inverse_perspective_pixel_map_tb
// Self-checking bench for the canvas-to-source projective pixel map.
// A directed table covers reset mapping, image edges, rounding of exact
// halves, zero denominator, negative denominator and size extremes. Random
// phases then load affine, projective and raw matrices and stream pixels
// with bursty input and a stalling output, each result checked against
// an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_perspective_pixel_map_tb;

    import ippm_pkg::*;

    localparam logic [3:0] CFG_UNUSED  = 4'd8;   // past the register list
    localparam int         DRAIN_CYC   = 40;     // pipeline is 22 deep
    localparam int         RAND_ITEMS  = 1250;
    localparam logic [15:0] OFF_MAP    = 16'hFFFF;

    typedef struct packed {
        logic        valid;
        logic [15:0] col;
        logic [15:0] row;
    } t_pix;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [3:0]  idx;
        logic [63:0] data;
        logic [15:0] cx;
        logic [15:0] cy;
        bit          typed;   // expected result given in the table
        t_pix        want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] canvas column, [31:16] canvas row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [15:0] source_col, [31:16] source_row
    logic        m_axis_tuser;        // [0] map_valid
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    t_cfg        map_cfg;             // predictor copy of the registers
    t_pix        pending_pix[$];      // results still owed by the block
    int          mismatch_cnt = 0;
    int          burst_left = 0;
    int          sent_cnt = 0;
    t_stim_row   stim_table[$];

    always #2 i_clk = ~i_clk;

    inverse_perspective_pixel_map DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Append one row to the directed table.
    function automatic void add_row(t_stim_row row);
        stim_table = {stim_table, row};
    endfunction

    // Round num/den (den > 0) to a pixel and test it against the size.
    function automatic bit axis_fit(longint num, longint den, logic [15:0] size,
                                    output logic [15:0] q);
        longint n;
        longint quo;
        n = num * 128 + den;
        q = OFF_MAP;
        if (n <= 0) return 1'b0;
        quo = n / (2 * den);
        if (quo >= longint'(size)) return 1'b0;
        q = quo[15:0];
        return 1'b1;
    endfunction

    // Project one canvas pixel through the current matrix.
    function automatic t_pix map_pixel(logic [15:0] cx, logic [15:0] cy);
        longint x, y, nx, ny, w;
        logic [15:0] qc, qr;
        t_pix r;
        x  = longint'(cx);
        y  = longint'(cy);
        nx = longint'($signed(map_cfg.row0_lin[63:32])) * x
           + longint'($signed(map_cfg.row0_lin[31:0])) * y
           + longint'($signed(map_cfg.row0_off));
        ny = longint'($signed(map_cfg.row1_lin[63:32])) * x
           + longint'($signed(map_cfg.row1_lin[31:0])) * y
           + longint'($signed(map_cfg.row1_off));
        w  = longint'($signed(map_cfg.row2_lin[63:32])) * x
           + longint'($signed(map_cfg.row2_lin[31:0])) * y
           + longint'($signed(map_cfg.row2_off));
        r = '{1'b0, OFF_MAP, OFF_MAP};
        if (w != 0) begin
            if (w < 0) begin
                w  = -w;
                nx = -nx;
                ny = -ny;
            end
            if (axis_fit(nx, w, map_cfg.src_w, qc) && axis_fit(ny, w, map_cfg.src_h, qr))
                r = '{1'b1, qc, qr};
        end
        return r;
    endfunction

    // Mirror one register write into the predictor.
    function automatic void apply_cfg(logic [3:0] idx, logic [63:0] d);
        case (idx)
            CFG_ROW0_LIN: map_cfg.row0_lin = d;
            CFG_ROW0_OFF: map_cfg.row0_off = d[47:0];
            CFG_ROW1_LIN: map_cfg.row1_lin = d;
            CFG_ROW1_OFF: map_cfg.row1_off = d[47:0];
            CFG_ROW2_LIN: map_cfg.row2_lin = d;
            CFG_ROW2_OFF: map_cfg.row2_off = d[31:0];
            CFG_SRC_W:    map_cfg.src_w    = d[15:0];
            CFG_SRC_H:    map_cfg.src_h    = d[15:0];
            default: ;
        endcase
    endfunction

    // Hold the sender and wait until every owed result is back, then
    // let the pipeline settle. Called at a falling edge.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [3:0] idx, logic [63:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drive one pixel; bursts of random length with random gaps between.
    task automatic send_pixel(logic [15:0] cx, logic [15:0] cy, bit typed, t_pix want);
        t_pix exp_pix;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_pix = typed ? want : map_pixel(cx, cy);
        pending_pix = {pending_pix, exp_pix};
        sent_cnt++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_signed(int unsigned span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // Load a random matrix and size for one phase of the random part.
    task automatic load_random_cfg();
        int unsigned mode;
        logic [31:0] a0, b0, a1, b1, g, h, k;
        logic [47:0] c0, c1;
        bit          flip;
        logic [15:0] sw, sh;
        mode = $urandom_range(0, 99);
        flip = $urandom_range(0, 3) == 0;   // negative denominator path
        a0 = 32'h0100_0000 + rand_signed(32'h0080_0000);
        b0 = rand_signed(32'h0040_0000);
        a1 = rand_signed(32'h0040_0000);
        b1 = 32'h0100_0000 + rand_signed(32'h0080_0000);
        c0 = 48'($signed(rand_signed(400))) <<< 24 | 48'($urandom_range(0, 32'hFF_FFFF));
        c1 = 48'($signed(rand_signed(400))) <<< 24 | 48'($urandom_range(0, 32'hFF_FFFF));
        g  = (mode < 45) ? 32'd0 : rand_signed(32'h0001_0000);
        h  = (mode < 45) ? 32'd0 : rand_signed(32'h0001_0000);
        k  = 32'h4000_0000;
        if (flip) begin
            a0 = -a0; b0 = -b0; a1 = -a1; b1 = -b1;
            c0 = -c0; c1 = -c1; g = -g; h = -h; k = -k;
        end
        case ($urandom_range(0, 9))
            0:       begin sw = 16'd1;     sh = 16'd1;     end
            1:       begin sw = 16'd65534; sh = 16'd65534; end
            2:       begin sw = 16'($urandom_range(1, 40)); sh = 16'($urandom_range(1, 40)); end
            default: begin sw = 16'($urandom_range(64, 2048));
                           sh = 16'($urandom_range(64, 2048)); end
        endcase
        if (mode >= 85) begin
            // raw noise on every register bit
            cfg_write(CFG_ROW0_LIN, {$urandom, $urandom});
            cfg_write(CFG_ROW0_OFF, {$urandom, $urandom});
            cfg_write(CFG_ROW1_LIN, {$urandom, $urandom});
            cfg_write(CFG_ROW1_OFF, {$urandom, $urandom});
            cfg_write(CFG_ROW2_LIN, {$urandom, $urandom});
            cfg_write(CFG_ROW2_OFF, {32'd0, $urandom});
            cfg_write(CFG_SRC_W, {48'd0, 16'($urandom)});
            cfg_write(CFG_SRC_H, {48'd0, 16'($urandom)});
        end else begin
            cfg_write(CFG_ROW0_LIN, {a0, b0});
            cfg_write(CFG_ROW0_OFF, {{16{c0[47]}}, c0});
            cfg_write(CFG_ROW1_LIN, {a1, b1});
            cfg_write(CFG_ROW1_OFF, {{16{c1[47]}}, c1});
            cfg_write(CFG_ROW2_LIN, {g, h});
            cfg_write(CFG_ROW2_OFF, {{32{k[31]}}, k});
            cfg_write(CFG_SRC_W, {48'd0, sw});
            cfg_write(CFG_SRC_H, {48'd0, sh});
        end
    endtask

    // Output stall pattern: switch at random between always ready, coin flip
    // and mostly stalled.
    int unsigned stall_mode = 0;
    int unsigned stall_cyc = 0;
    always @(negedge i_clk) begin
        if (stall_cyc == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cyc  = $urandom_range(50, 300);
        end
        stall_cyc--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check each output transfer against the oldest owed result.
    always @(posedge i_clk) begin
        t_pix got;
        t_pix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]};
            if (pending_pix.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected result valid=%0b col=%0d row=%0d",
                             $realtime, got.valid, got.col, got.row);
            end else begin
                want = pending_pix.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: exp v/c/r %0b/%0d/%0d, got %0b/%0d/%0d",
                                 $realtime, want.valid, want.col, want.row,
                                 got.valid, got.col, got.row);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_stim_row r;
        t_pix      off;
        off = '{1'b0, OFF_MAP, OFF_MAP};
        map_cfg = '{64'h0100_0000_0000_0000, 48'd0, 64'h0000_0000_0100_0000, 48'd0,
                    64'd0, 32'h4000_0000, 16'd1920, 16'd1080};

        // Reset mapping is the identity onto a 1920x1080 source.
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd0,     16'd0,     1, '{1'b1, 16'd0, 16'd0}});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd1919,  16'd1079,  1, '{1'b1, 16'd1919, 16'd1079}});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd1920,  16'd0,     1, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd0,     16'd1080,  1, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd65534, 16'd65534, 1, off});
        // Exact half rounds up: shift columns by half a pixel.
        add_row('{ROW_CFG, CFG_ROW0_OFF, 64'h80_0000, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd0,     16'd5,     1, '{1'b1, 16'd1, 16'd5}});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd1918,  16'd7,     1, '{1'b1, 16'd1919, 16'd7}});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd1919,  16'd7,     1, off});
        // Index past the register list is dropped.
        add_row('{ROW_CFG, CFG_UNUSED, {32{2'b10}}, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd3,     16'd4,     0, off});
        // Negative denominator with every row negated, row 1 offset set to its largest positive value.
        add_row('{ROW_CFG, CFG_ROW0_LIN, 64'hFF00_0000_0000_0000, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW0_OFF, 64'hFFFF_FFFF_FF80_0000, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW1_LIN, 64'h0000_0000_FF00_0000, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW1_OFF, 64'h0000_7FFF_FFFF_FFFF, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW2_OFF, 64'hFFFF_FFFF_C000_0000, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd5,     16'd9,     0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd100,   16'd200,   0, off});
        // Size extremes: largest accepted, then zero.
        add_row('{ROW_CFG, CFG_ROW1_OFF, 64'd0, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_SRC_W, 64'd65535, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_SRC_H, 64'd65535, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd65534, 16'd65534, 0, off});
        add_row('{ROW_CFG, CFG_SRC_W, 64'd0, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd0,     16'd0,     1, off});
        // Zero denominator: every pixel is off the map.
        add_row('{ROW_CFG, CFG_SRC_W, 64'd1920, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW2_LIN, 64'd0, 16'd0, 16'd0, 0, off});
        add_row('{ROW_CFG, CFG_ROW2_OFF, 64'd0, 16'd0, 16'd0, 0, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd1,     16'd1,     1, off});
        add_row('{ROW_PIX, 4'd0, 64'd0, 16'd65534, 16'd0,     1, off});

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table; registers change only with the block idle.
        foreach (stim_table[i]) begin
            r = stim_table[i];
            if (r.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(r.idx, r.data);
            end else begin
                send_pixel(r.cx, r.cy, r.typed, r.want);
            end
        end

        // Random phases, each on a fresh matrix; pixels mostly near the origin.
        sent_cnt = 0;
        while (sent_cnt < RAND_ITEMS) begin
            wait_idle();
            load_random_cfg();
            repeat ($urandom_range(60, 200)) begin
                if ($urandom_range(0, 4) == 0)
                    send_pixel(16'($urandom_range(0, 65534)), 16'($urandom_range(0, 65534)),
                               0, off);
                else
                    send_pixel(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)),
                               0, off);
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_pix.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
